@@ rtl/core/ffha_pkg.sv @@
package ffha_pkg;

   localparam int DATA_W  = 12;
   localparam int COUNT_W = 9;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_INFO  = 2'd2;

   localparam logic [2:0] RD_IDLE     = 3'd0;
   localparam logic [2:0] RD_ZERO     = 3'd1;
   localparam logic [2:0] RD_NEXT     = 3'd2;
   localparam logic [2:0] RD_PREV     = 3'd3;
   localparam logic [2:0] RD_LAST     = 3'd4;
   localparam logic [2:0] RD_HIT_UP   = 3'd5;
   localparam logic [2:0] RD_HIT_DOWN = 3'd6;
   localparam logic [2:0] RD_DROP     = 3'd7;

   localparam logic [2:0] WR_NONE      = 3'd0;
   localparam logic [2:0] WR_INIT      = 3'd1;
   localparam logic [2:0] WR_MOVE_UP   = 3'd2;
   localparam logic [2:0] WR_MOVE_DOWN = 3'd3;
   localparam logic [2:0] WR_SPLIT     = 3'd4;
   localparam logic [2:0] WR_MARK      = 3'd5;
   localparam logic [2:0] WR_MERGED    = 3'd6;

   localparam logic [1:0] TOT_HOLD = 2'd0;
   localparam logic [1:0] TOT_INIT = 2'd1;
   localparam logic [1:0] TOT_INC  = 2'd2;
   localparam logic [1:0] TOT_SUB  = 2'd3;

   typedef struct packed {
      logic [1:0]        func;
      logic [DATA_W-1:0] request_size;
      logic [DATA_W-1:0] release_offset;
   } ffha_req_type;

   typedef struct packed {
      logic               failed;
      logic [DATA_W-1:0]  payload_offset;
      logic [DATA_W-1:0]  largest_free;
      logic [COUNT_W-1:0] used_blocks;
      logic [DATA_W-1:0]  used_bytes;
   } ffha_rsp_type;

   typedef struct packed {
      logic       load;
      logic [2:0] rd_op;
      logic [2:0] wr_op;
      logic [1:0] tot_op;
      logic       pos_add;
      logic       capture;
      logic       merge_next;
      logic       merge_prev;
      logic       stat_add;
      logic       set_fail;
      logic       latch_split;
      logic       push;
   } ffha_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       is_last;
      logic       fit;
      logic       pos_before;
      logic       pos_match;
      logic       split_ok;
      logic       has_next;
      logic       has_prev;
      logic       shift_last;
      logic       drop_any;
      logic       size_zero;
      logic       off_low;
      logic       out_free;
   } ffha_status_type;

endpackage

@@ rtl/core/ffha_ram.sv @@
module ffha_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ffha_ctrl.sv @@
module ffha_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ffha_pkg::ffha_status_type status,
   output ffha_pkg::ffha_cmd_type    cmd
);

   import ffha_pkg::*;

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_ASCAN    = 4'd3;
   localparam logic [3:0] S_APLAN    = 4'd4;
   localparam logic [3:0] S_ASHIFT   = 4'd5;
   localparam logic [3:0] S_ASPLIT   = 4'd6;
   localparam logic [3:0] S_AMARK    = 4'd7;
   localparam logic [3:0] S_FSCAN    = 4'd8;
   localparam logic [3:0] S_FHIT     = 4'd9;
   localparam logic [3:0] S_FNEXT    = 4'd10;
   localparam logic [3:0] S_FPREV    = 4'd11;
   localparam logic [3:0] S_FWRITE   = 4'd12;
   localparam logic [3:0] S_FDROP    = 4'd13;
   localparam logic [3:0] S_ISCAN    = 4'd14;
   localparam logic [3:0] S_OUT      = 4'd15;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.wr_op  = WR_INIT;
            cmd.tot_op = TOT_INIT;
            state_in   = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.func)
               FUNC_ALLOC: begin
                  if (status.size_zero) begin
                     cmd.set_fail = 1'b1;
                     state_in     = S_OUT;
                  end else begin
                     cmd.rd_op = RD_ZERO;
                     state_in  = S_ASCAN;
                  end
               end
               FUNC_FREE: begin
                  if (status.off_low) begin
                     cmd.set_fail = 1'b1;
                     state_in     = S_OUT;
                  end else begin
                     cmd.rd_op = RD_ZERO;
                     state_in  = S_FSCAN;
                  end
               end
               FUNC_INFO: begin
                  cmd.rd_op = RD_ZERO;
                  state_in  = S_ISCAN;
               end
               default: begin
                  cmd.set_fail = 1'b1;
                  state_in     = S_OUT;
               end
            endcase
         end
         S_ASCAN: begin
            if (status.fit) begin
               cmd.capture = 1'b1;
               state_in    = S_APLAN;
            end else begin
               cmd.pos_add = 1'b1;
               if (status.is_last) begin
                  cmd.set_fail = 1'b1;
                  state_in     = S_OUT;
               end else begin
                  cmd.rd_op = RD_NEXT;
               end
            end
         end
         S_APLAN: begin
            cmd.latch_split = 1'b1;
            if (status.split_ok && status.has_next) begin
               cmd.rd_op = RD_LAST;
               state_in  = S_ASHIFT;
            end else if (status.split_ok) begin
               state_in = S_ASPLIT;
            end else begin
               state_in = S_AMARK;
            end
         end
         S_ASHIFT: begin
            cmd.wr_op = WR_MOVE_UP;
            if (status.shift_last) begin
               state_in = S_ASPLIT;
            end else begin
               cmd.rd_op = RD_PREV;
            end
         end
         S_ASPLIT: begin
            cmd.wr_op  = WR_SPLIT;
            cmd.tot_op = TOT_INC;
            state_in   = S_AMARK;
         end
         S_AMARK: begin
            cmd.wr_op = WR_MARK;
            state_in  = S_OUT;
         end
         S_FSCAN: begin
            if (status.pos_before) begin
               cmd.pos_add = 1'b1;
               if (status.is_last) begin
                  cmd.set_fail = 1'b1;
                  state_in     = S_OUT;
               end else begin
                  cmd.rd_op = RD_NEXT;
               end
            end else if (status.pos_match) begin
               cmd.capture = 1'b1;
               state_in    = S_FHIT;
            end else begin
               cmd.set_fail = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_FHIT: begin
            if (status.has_next) begin
               cmd.rd_op = RD_HIT_UP;
               state_in  = S_FNEXT;
            end else if (status.has_prev) begin
               cmd.rd_op = RD_HIT_DOWN;
               state_in  = S_FPREV;
            end else begin
               state_in = S_FWRITE;
            end
         end
         S_FNEXT: begin
            cmd.merge_next = 1'b1;
            if (status.has_prev) begin
               cmd.rd_op = RD_HIT_DOWN;
               state_in  = S_FPREV;
            end else begin
               state_in = S_FWRITE;
            end
         end
         S_FPREV: begin
            cmd.merge_prev = 1'b1;
            state_in       = S_FWRITE;
         end
         S_FWRITE: begin
            cmd.wr_op = WR_MERGED;
            if (status.drop_any) begin
               cmd.rd_op = RD_DROP;
               state_in  = S_FDROP;
            end else begin
               cmd.tot_op = TOT_SUB;
               state_in   = S_OUT;
            end
         end
         S_FDROP: begin
            cmd.wr_op = WR_MOVE_DOWN;
            if (status.is_last) begin
               cmd.tot_op = TOT_SUB;
               state_in   = S_OUT;
            end else begin
               cmd.rd_op = RD_NEXT;
            end
         end
         S_ISCAN: begin
            cmd.stat_add = 1'b1;
            if (status.is_last) begin
               state_in = S_OUT;
            end else begin
               cmd.rd_op = RD_NEXT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/ffha_datapath.sv @@
module ffha_datapath #(
   parameter int HEAP_BYTES      = 4096,
   parameter int HEADER_BYTES    = 8,
   parameter int MIN_BLOCK_BYTES = 8,
   parameter int MAX_BLOCKS      = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ffha_pkg::ffha_req_type    req_data,
   output ffha_pkg::ffha_rsp_type    rsp_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  ffha_pkg::ffha_cmd_type    cmd,
   output ffha_pkg::ffha_status_type status
);

   import ffha_pkg::*;

   localparam int LW = $clog2(HEAP_BYTES + 1);
   localparam int XW = (LW + 2 > DATA_W + 1) ? LW + 2 : DATA_W + 1;
   localparam int CW = (LW > DATA_W) ? LW : DATA_W;
   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int TW = $clog2(MAX_BLOCKS + 1);
   localparam int DW = TW + 1;
   localparam int NW = (TW > COUNT_W) ? TW : COUNT_W;
   localparam int SPLIT_MIN = (MIN_BLOCK_BYTES > HEADER_BYTES) ? MIN_BLOCK_BYTES : HEADER_BYTES;
   localparam logic [XW-1:0] HDR   = XW'(HEADER_BYTES);
   localparam logic [XW-1:0] SMIN  = XW'(SPLIT_MIN);
   localparam logic [LW-1:0] FIRST = LW'(HEAP_BYTES - HEADER_BYTES);

   ffha_req_type  req_ff;
   ffha_rsp_type  rsp_ff;
   logic          rsp_valid_ff;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [TW-1:0] total_ff, total_in;
   logic [XW-1:0] pos_ff;
   logic [XW-1:0] hitpos_ff;
   logic [AW-1:0] hit_ff;
   logic [LW-1:0] acc_ff;
   logic          split_ff;
   logic          nfree_ff;
   logic          pfree_ff;
   logic          fail_ff;
   logic [TW-1:0] cnt_ff;
   logic [LW-1:0] bytes_ff;
   logic [LW-1:0] largest_ff;

   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [LW:0]   wr_data;
   logic [LW:0]   ram_q;
   logic [LW-1:0] len_q;
   logic          use_q;
   logic [XW-1:0] len_x;
   logic [XW-1:0] size_x;
   logic [XW-1:0] off_x;
   logic [XW-1:0] acc_x;
   logic [AW-1:0] drop_d;
   logic [DW-1:0] drop_src;
   logic [CW-1:0] off_out;
   logic [CW-1:0] largest_out;
   logic [CW-1:0] bytes_out;
   logic [NW-1:0] cnt_out;
   ffha_rsp_type  rsp_in;

   ffha_ram #(
      .WIDTH(LW + 1),
      .DEPTH(MAX_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign len_q    = ram_q[LW-1:0];
   assign use_q    = ram_q[LW];
   assign len_x    = XW'(len_q);
   assign size_x   = XW'(req_ff.request_size);
   assign off_x    = XW'(req_ff.release_offset);
   assign acc_x    = XW'(acc_ff);
   assign drop_d   = AW'(nfree_ff) + AW'(pfree_ff);
   assign drop_src = DW'(hit_ff) + DW'(1) + DW'(nfree_ff);

   always_comb begin
      case (cmd.rd_op)
         RD_ZERO:     rd_addr = '0;
         RD_NEXT:     rd_addr = rd_idx_ff + AW'(1);
         RD_PREV:     rd_addr = rd_idx_ff - AW'(1);
         RD_LAST:     rd_addr = AW'(total_ff - TW'(1));
         RD_HIT_UP:   rd_addr = hit_ff + AW'(1);
         RD_HIT_DOWN: rd_addr = hit_ff - AW'(1);
         RD_DROP:     rd_addr = AW'(drop_src);
         default:     rd_addr = rd_idx_ff;
      endcase
      rd_idx_in = rd_addr;
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = hit_ff;
      wr_data = ram_q;
      case (cmd.wr_op)
         WR_INIT: begin
            wr_addr = '0;
            wr_data = {1'b0, FIRST};
         end
         WR_MOVE_UP: begin
            wr_addr = rd_idx_ff + AW'(1);
         end
         WR_MOVE_DOWN: begin
            wr_addr = rd_idx_ff - drop_d;
         end
         WR_SPLIT: begin
            wr_addr = hit_ff + AW'(1);
            wr_data = {1'b0, LW'(acc_x - size_x - HDR)};
         end
         WR_MARK: begin
            wr_data = {1'b1, split_ff ? LW'(size_x) : acc_ff};
         end
         WR_MERGED: begin
            wr_addr = pfree_ff ? hit_ff - AW'(1) : hit_ff;
            wr_data = {1'b0, acc_ff};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (cmd.tot_op)
         TOT_INIT: total_in = TW'(1);
         TOT_INC:  total_in = total_ff + TW'(1);
         TOT_SUB:  total_in = total_ff - TW'(nfree_ff) - TW'(pfree_ff);
         default:  total_in = total_ff;
      endcase
   end

   always_comb begin
      status.func       = req_ff.func;
      status.is_last    = (TW'(rd_idx_ff) + TW'(1)) == total_ff;
      status.fit        = !use_q && (len_x >= size_x);
      status.pos_before = (pos_ff + HDR) < off_x;
      status.pos_match  = use_q && ((pos_ff + HDR) == off_x);
      status.split_ok   = (acc_x >= size_x + SMIN) && (total_ff < TW'(MAX_BLOCKS));
      status.has_next   = (TW'(hit_ff) + TW'(1)) < total_ff;
      status.has_prev   = hit_ff != '0;
      status.shift_last = rd_idx_ff == hit_ff + AW'(1);
      status.drop_any   = (nfree_ff || pfree_ff) && (drop_src < DW'(total_ff));
      status.size_zero  = req_ff.request_size == '0;
      status.off_low    = off_x < HDR;
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      off_out     = CW'(hitpos_ff + HDR);
      largest_out = CW'(largest_ff);
      bytes_out   = CW'(bytes_ff);
      cnt_out     = NW'(cnt_ff);
      rsp_in      = '0;
      rsp_in.failed = fail_ff;
      if (req_ff.func == FUNC_ALLOC && !fail_ff) begin
         rsp_in.payload_offset = off_out[DATA_W-1:0];
      end
      if (req_ff.func == FUNC_INFO) begin
         rsp_in.largest_free = largest_out[DATA_W-1:0];
         rsp_in.used_blocks  = cnt_out[COUNT_W-1:0];
         rsp_in.used_bytes   = bytes_out[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      total_ff  <= total_in;
      if (cmd.push) begin
         rsp_ff <= rsp_in;
      end
      if (cmd.load) begin
         req_ff     <= req_data;
         pos_ff     <= '0;
         fail_ff    <= 1'b0;
         nfree_ff   <= 1'b0;
         pfree_ff   <= 1'b0;
         cnt_ff     <= '0;
         bytes_ff   <= '0;
         largest_ff <= '0;
      end
      if (cmd.pos_add) begin
         pos_ff <= pos_ff + HDR + len_x;
      end
      if (cmd.capture) begin
         hit_ff    <= rd_idx_ff;
         acc_ff    <= len_q;
         hitpos_ff <= pos_ff;
      end
      if (cmd.merge_next && !use_q) begin
         acc_ff   <= LW'(acc_x + HDR + len_x);
         nfree_ff <= 1'b1;
      end
      if (cmd.merge_prev && !use_q) begin
         acc_ff   <= LW'(acc_x + HDR + len_x);
         pfree_ff <= 1'b1;
      end
      if (cmd.stat_add) begin
         if (use_q) begin
            cnt_ff   <= cnt_ff + TW'(1);
            bytes_ff <= bytes_ff + len_q;
         end else if (len_q > largest_ff) begin
            largest_ff <= len_q;
         end
      end
      if (cmd.set_fail) begin
         fail_ff <= 1'b1;
      end
      if (cmd.latch_split) begin
         split_ff <= status.split_ok;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/first_fit_heap_allocator.sv @@
// First-fit heap allocator with coalescing of free neighbors.
// Requests arrive on the req_ channel (valid/ready); each request beat
// carries a function code: allocate, free, or usage report. Every request
// produces exactly one response beat on the rsp_ channel.
// The block list lives in one single-port-read RAM of MAX_BLOCKS entries.
// Allocate, free and report walk the list one entry per cycle; a split shifts
// the later entries up one per cycle and a free that merges shifts them down
// one per cycle. The scan and the shift together visit each entry about
// once; one request is processed at a time.
// The response waits in an output register, so a stalled receiver holds
// only that beat; the next request is taken once the previous response has
// been stored, and it finishes only when the register is free again.
// After reset the block writes the first list entry (the whole heap as one
// free block) in its init state before req_ready goes high.
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES      = 4096,
   parameter int HEADER_BYTES    = 8,
   parameter int MIN_BLOCK_BYTES = 8,
   parameter int MAX_BLOCKS      = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ffha_pkg::ffha_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ffha_pkg::ffha_rsp_type rsp_data
);

   import ffha_pkg::*;

   ffha_cmd_type    cmd;
   ffha_status_type status;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ffha_datapath #(
      .HEAP_BYTES      (HEAP_BYTES),
      .HEADER_BYTES    (HEADER_BYTES),
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
      .MAX_BLOCKS      (MAX_BLOCKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

@@ dv/tb_first_fit_heap_allocator.sv @@
module tb_first_fit_heap_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   import ffha_pkg::*;

   localparam int HEAP_BYTES      = 4096;
   localparam int HEADER_BYTES    = 8;
   localparam int MIN_BLOCK_BYTES = 8;
   localparam int MAX_BLOCKS      = 256;
   localparam logic [1:0] FUNC_BAD = 2'd3;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   ffha_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   ffha_rsp_type rsp_data;

   int unsigned  heap_len [MAX_BLOCKS];
   bit           heap_used [MAX_BLOCKS];
   int unsigned  heap_count;
   ffha_rsp_type pending_rsp [$];
   int unsigned  live_offsets [$];
   int           errors;
   int           send_idle_pct;
   int           recv_stall_pct;
   bit           hold_off;

   first_fit_heap_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #100ms;
      $display("first_fit_heap_allocator: mismatch");
      $finish;
   end

   function automatic void heap_reset();
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         heap_len[k]  = 0;
         heap_used[k] = 1'b0;
      end
      heap_len[0] = HEAP_BYTES - HEADER_BYTES;
      heap_count  = 1;
   endfunction

   function automatic void heap_drop(int unsigned idx);
      for (int unsigned k = idx; k + 1 < heap_count; k++) begin
         heap_len[k]  = heap_len[k+1];
         heap_used[k] = heap_used[k+1];
      end
      heap_count--;
   endfunction

   function automatic ffha_rsp_type heap_apply(ffha_req_type rq);
      ffha_rsp_type r;
      int unsigned  i, pos, rem, sz, off, largest, cnt, bytes;
      r = '0;
      r.failed = 1'b1;
      case (rq.func)
         FUNC_ALLOC: begin
            sz  = rq.request_size;
            pos = 0;
            if (sz != 0) begin
               for (i = 0; i < heap_count; i++) begin
                  if (!heap_used[i] && heap_len[i] >= sz) break;
                  pos += HEADER_BYTES + heap_len[i];
               end
               if (i < heap_count) begin
                  rem = heap_len[i] - sz;
                  if (rem >= MIN_BLOCK_BYTES && rem >= HEADER_BYTES &&
                      heap_count < MAX_BLOCKS) begin
                     for (int unsigned k = heap_count; k > i + 1; k--) begin
                        heap_len[k]  = heap_len[k-1];
                        heap_used[k] = heap_used[k-1];
                     end
                     heap_len[i+1]  = rem - HEADER_BYTES;
                     heap_used[i+1] = 1'b0;
                     heap_len[i]    = sz;
                     heap_count++;
                  end
                  heap_used[i] = 1'b1;
                  r.failed = 1'b0;
                  r.payload_offset = DATA_W'(pos + HEADER_BYTES);
                  live_offsets.push_back(pos + HEADER_BYTES);
               end
            end
         end
         FUNC_FREE: begin
            off = rq.release_offset;
            i   = 0;
            pos = 0;
            if (off >= HEADER_BYTES) begin
               while (i < heap_count && pos + HEADER_BYTES < off) begin
                  pos += HEADER_BYTES + heap_len[i];
                  i++;
               end
               if (i < heap_count && heap_used[i] && pos + HEADER_BYTES == off) begin
                  heap_used[i] = 1'b0;
                  if (i + 1 < heap_count && !heap_used[i+1]) begin
                     heap_len[i] += HEADER_BYTES + heap_len[i+1];
                     heap_drop(i + 1);
                  end
                  if (i > 0 && !heap_used[i-1]) begin
                     heap_len[i-1] += HEADER_BYTES + heap_len[i];
                     heap_drop(i);
                  end
                  r.failed = 1'b0;
                  foreach (live_offsets[q])
                     if (live_offsets[q] == off) begin
                        live_offsets.delete(q);
                        break;
                     end
               end
            end
         end
         FUNC_INFO: begin
            largest = 0;
            cnt     = 0;
            bytes   = 0;
            for (i = 0; i < heap_count; i++) begin
               if (heap_used[i]) begin
                  cnt++;
                  bytes += heap_len[i];
               end else if (heap_len[i] > largest) begin
                  largest = heap_len[i];
               end
            end
            r.failed       = 1'b0;
            r.largest_free = DATA_W'(largest);
            r.used_blocks  = COUNT_W'(cnt);
            r.used_bytes   = DATA_W'(bytes);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_beat(logic [1:0] fn, int unsigned sz, int unsigned off);
      ffha_req_type rq;
      rq.func           = fn;
      rq.request_size   = DATA_W'(sz);
      rq.release_offset = DATA_W'(off);
      do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(heap_apply(rq));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_alloc(int unsigned sz);
      send_beat(FUNC_ALLOC, sz, $urandom);
   endtask

   task automatic send_free(int unsigned off);
      send_beat(FUNC_FREE, $urandom, off);
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected beat %p", $realtime, rsp_data);
            errors++;
         end else begin
            if (rsp_data.failed !== pending_rsp[0].failed ||
                rsp_data.payload_offset !== pending_rsp[0].payload_offset ||
                rsp_data.largest_free !== pending_rsp[0].largest_free ||
                rsp_data.used_blocks !== pending_rsp[0].used_blocks ||
                rsp_data.used_bytes !== pending_rsp[0].used_bytes) begin
               $display("%0t: expected %p actual %p", $realtime, pending_rsp[0], rsp_data);
               errors++;
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   task automatic test_directed();
      send_beat(FUNC_INFO, 0, 0);
      send_alloc(0);
      send_alloc(4095);
      send_alloc(HEAP_BYTES - HEADER_BYTES);
      send_beat(FUNC_INFO, 4095, 4095);
      send_free(HEADER_BYTES);
      send_alloc(1);
      send_alloc(10);
      send_alloc(20);
      send_alloc(3000);
      send_free(0);
      send_free(7);
      send_free(9);
      send_free(4095);
      send_free(2 * HEADER_BYTES + 10);
      send_free(2 * HEADER_BYTES + 10);
      send_free(HEADER_BYTES + 1 + 8 + 16);
      send_beat(FUNC_BAD, 4095, 4095);
      send_beat(FUNC_INFO, 0, 0);
      send_free(HEADER_BYTES);
      send_beat(FUNC_INFO, 0, 0);
   endtask

   task automatic random_step();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         pick = $urandom_range(9);
         if (pick < 7) send_alloc($urandom_range(1, 24));
         else if (pick < 9) send_alloc($urandom_range(1, 300));
         else send_alloc($urandom);
      end else if (pick < 85 && live_offsets.size() != 0) begin
         send_free(live_offsets[$urandom_range(live_offsets.size() - 1)]);
      end else if (pick < 92) begin
         send_beat(FUNC_INFO, $urandom, $urandom);
      end else if (pick < 98) begin
         send_free($urandom);
      end else begin
         send_beat(FUNC_BAD, $urandom, $urandom);
      end
   endtask

   task automatic test_random(int n, int idle, int stall);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (n) random_step();
      send_idle_pct  = 0;
      wait_drained();
   endtask

   task automatic test_table_full();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (280) send_alloc(1);
      send_beat(FUNC_INFO, 0, 0);
      while (live_offsets.size() != 0) send_free(live_offsets[0]);
      send_beat(FUNC_INFO, 0, 0);
      wait_drained();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(negedge clock);
            hold_off = 1'b0;
         end
         repeat (12) random_step();
      join
      wait_drained();
   endtask

   initial begin
      errors         = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off       = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      heap_reset();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(300, 0, 0);
      test_random(280, 57, 0);
      test_random(280, 0, 57);
      test_random(270, 27, 27);
      test_table_full();
      test_backpressure();
      wait_drained();
      repeat (600) @(negedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("first_fit_heap_allocator: match");
      end else begin
         $display("first_fit_heap_allocator: mismatch");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_ctrl.sv
rtl/core/ffha_datapath.sv
rtl/core/first_fit_heap_allocator.sv
dv/tb_first_fit_heap_allocator.sv
